>>> rtl/kfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_pkg
// Shared types, register codes and constants of the keyed field extractor.
// ----------------------------------------------------------------------------
package kfe_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned MaxKeyChars   = 12;
  localparam int unsigned MaxValueChars = 4096;

  // Depth of the request queue between front and back.
  localparam int unsigned QueueDepth = 4;

  // Field and register widths.
  localparam int unsigned CharW     = 8;
  localparam int unsigned ValueLenW = 12;
  localparam int unsigned KeyLowW   = 64;
  localparam int unsigned KeyHighW  = 32;
  localparam int unsigned KeyLenW   = 4;
  localparam int unsigned ValueCapW = 13;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 64;

  // Register reset values.
  localparam logic [KeyLenW-1:0]   KeyLenReset   = 4'd3;
  localparam logic [ValueCapW-1:0] ValueCapReset = 13'd64;

  // Characters with a special meaning.
  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharTab   = 8'h09;
  localparam logic [CharW-1:0] CharLf    = 8'h0A;
  localparam logic [CharW-1:0] CharCr    = 8'h0D;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharEqual = 8'h3D;

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    CFG_KEY_LOW      = 3'd0,
    CFG_KEY_HIGH     = 3'd1,
    CFG_KEY_LEN      = 3'd2,
    CFG_VALUE_CAP    = 3'd3,
    CFG_REQ_NONEMPTY = 3'd4
  } cfg_reg_e;

  // Line parsing phase.
  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_VALUE  = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  // One request from the front: an optional value character and an optional
  // closing report, in that order.
  typedef struct packed {
    logic                 has_char;
    logic [CharW-1:0]     value_char;
    logic                 finish;
    logic                 found;
    logic [ValueLenW-1:0] value_length;
  } kfe_entry_t;

endpackage

>>> rtl/kfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_front
// Holds the configuration and the per-line parsing state, and classifies each
// accepted character into a request for the back end.
// ----------------------------------------------------------------------------
module kfe_front #(
  parameter int unsigned MAX_KEY_CHARS   = kfe_pkg::MaxKeyChars,
  parameter int unsigned MAX_VALUE_CHARS = kfe_pkg::MaxValueChars
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kfe_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [kfe_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          accept_i,
  input  logic [kfe_pkg::CharW-1:0]     text_char_i,
  input  logic                          end_of_text_i,
  output logic                          entry_valid_o,
  output kfe_pkg::kfe_entry_t           entry_o
);
  import kfe_pkg::*;

  localparam int unsigned WinDepth    = MAX_KEY_CHARS + 1;
  localparam int unsigned FillW       = $clog2(WinDepth + 1);
  localparam int unsigned SupW        = $clog2(MAX_KEY_CHARS + 1);
  localparam int unsigned CntW        = $clog2(MAX_VALUE_CHARS);
  localparam int unsigned MaxCapBits  = $clog2(MAX_VALUE_CHARS + 1);
  localparam int unsigned CapW        = (MaxCapBits > ValueCapW) ? MaxCapBits : ValueCapW;
  localparam int unsigned SumW        = CapW + 1;

  // Configuration registers.
  logic [KeyLowW-1:0]   key_low_q;
  logic [KeyHighW-1:0]  key_high_q;
  logic [KeyLenW-1:0]   key_len_q;
  logic [ValueCapW-1:0] value_cap_q;
  logic                 req_nonempty_q;

  // Line state.
  logic [CharW-1:0] win_q [WinDepth];
  logic [FillW-1:0] fill_q;
  logic [SupW-1:0]  sup_q, sup_d;
  phase_e           phase_q, phase_d, phase_step;
  logic [CntW-1:0]  count_q, count_d, count_step;

  // Per-character decode.
  logic             is_nul, is_term, is_equal, line_end;
  logic [4:0]       key_len_eff;
  logic [CharW-1:0] key_chars [MAX_KEY_CHARS];
  logic [MAX_KEY_CHARS-1:0] cand, bnd, sel;
  logic             hit, key_bounded, take_key;
  logic [CapW-1:0]  cap_eff;
  logic             cap_hit;
  logic             emit_char;
  logic             found;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q      <= '0;
      key_high_q     <= '0;
      key_len_q      <= KeyLenReset;
      value_cap_q    <= ValueCapReset;
      req_nonempty_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_KEY_LOW:      key_low_q      <= cfg_wdata_i[KeyLowW-1:0];
        CFG_KEY_HIGH:     key_high_q     <= cfg_wdata_i[KeyHighW-1:0];
        CFG_KEY_LEN:      key_len_q      <= cfg_wdata_i[KeyLenW-1:0];
        CFG_VALUE_CAP:    value_cap_q    <= cfg_wdata_i[ValueCapW-1:0];
        CFG_REQ_NONEMPTY: req_nonempty_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Character classes.
  assign is_nul   = (text_char_i == CharNul);
  assign is_term  = (text_char_i == CharTab) || (text_char_i == CharCr) ||
                    (text_char_i == CharLf);
  assign is_equal = (text_char_i == CharEqual);
  assign line_end = is_nul || end_of_text_i;

  // Effective key length: zero acts as one, long keys saturate.
  always_comb begin
    if (key_len_q == '0) begin
      key_len_eff = 5'd1;
    end else if ({1'b0, key_len_q} > 5'(MAX_KEY_CHARS)) begin
      key_len_eff = 5'(MAX_KEY_CHARS);
    end else begin
      key_len_eff = {1'b0, key_len_q};
    end
  end

  // Key characters; positions beyond the registers never match text.
  for (genvar i = 0; i < MAX_KEY_CHARS; i++) begin : g_key
    if (i < 8) begin : g_low
      assign key_chars[i] = key_low_q[8*i +: 8];
    end else if (i < 12) begin : g_high
      assign key_chars[i] = key_high_q[8*(i-8) +: 8];
    end else begin : g_none
      assign key_chars[i] = CharNul;
    end
  end

  // Parallel window compare, one comparator set for each possible key length.
  for (genvar kk = 1; kk <= MAX_KEY_CHARS; kk++) begin : g_len
    logic [kk-1:0] eq;
    for (genvar i = 0; i < kk; i++) begin : g_cmp
      assign eq[i] = (win_q[kk-1-i] == key_chars[i]);
    end
    assign cand[kk-1] = (&eq) && (fill_q >= FillW'(kk));
    assign bnd[kk-1]  = (fill_q == FillW'(kk)) || (win_q[kk] == CharTab) ||
                        (win_q[kk] == CharSpace);
    assign sel[kk-1]  = (key_len_eff == 5'(kk));
  end

  assign hit         = |(sel & cand);
  assign key_bounded = |(sel & bnd);
  assign take_key    = (sup_q == '0) && hit && key_bounded && is_equal;

  // Value length limit.
  always_comb begin
    if (req_nonempty_q) begin
      cap_eff = CapW'(MAX_VALUE_CHARS);
    end else if (CapW'(value_cap_q) > CapW'(MAX_VALUE_CHARS)) begin
      cap_eff = CapW'(MAX_VALUE_CHARS);
    end else begin
      cap_eff = CapW'(value_cap_q);
    end
  end
  assign cap_hit = (SumW'(count_q) + SumW'(1)) >= SumW'(cap_eff);

  // Phase after this character, before any end-of-line clear.
  always_comb begin
    phase_step = phase_q;
    if (!is_nul) begin
      unique case (phase_q)
        PH_SEARCH: if (take_key) phase_step = PH_VALUE;
        PH_VALUE:  if (is_term || cap_hit) phase_step = PH_DONE;
        PH_DONE:   phase_step = PH_DONE;
        default:   phase_step = PH_SEARCH;
      endcase
    end
  end

  // Next phase: a line end starts the next line in search.
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      phase_d = line_end ? PH_SEARCH : phase_step;
    end
  end

  // Outputs of the step: value character, counters and the closing report.
  always_comb begin
    emit_char  = !is_nul && (phase_q == PH_VALUE) && !is_term && !cap_hit;
    count_step = emit_char ? CntW'(count_q + 1'b1) : count_q;
    sup_d      = sup_q;
    if (!is_nul && (phase_q == PH_SEARCH)) begin
      if (sup_q != '0) begin
        sup_d = sup_q - 1'b1;
      end else if (hit && !take_key) begin
        sup_d = SupW'(key_len_eff - 5'd1);
      end
    end
    found   = (phase_step != PH_SEARCH) && (!req_nonempty_q || (count_step != '0));
    count_d = count_step;
    if (line_end) begin
      sup_d   = '0;
      count_d = '0;
    end
  end

  // Request toward the queue.
  assign entry_valid_o         = accept_i && (emit_char || line_end);
  assign entry_o.has_char      = emit_char;
  assign entry_o.value_char    = text_char_i;
  assign entry_o.finish        = line_end;
  assign entry_o.found         = found;
  assign entry_o.value_length  = ValueLenW'(count_step);

  // Line state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      sup_q   <= '0;
      count_q <= '0;
      fill_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      sup_q   <= sup_d;
      count_q <= count_d;
      if (line_end) begin
        fill_q <= '0;
      end else if (fill_q < FillW'(WinDepth)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Character window; entries beyond the fill count are never looked at.
  always_ff @(posedge clk_i) begin
    if (accept_i && !is_nul) begin
      win_q[0] <= text_char_i;
      for (int j = 1; j < WinDepth; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

endmodule

>>> rtl/kfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_queue
// Small register queue that carries requests from the front to the back.
// ----------------------------------------------------------------------------
module kfe_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kfe_pkg::kfe_entry_t entry_i,
  input  logic                pop_i,
  output kfe_pkg::kfe_entry_t entry_o,
  output logic                full_o,
  output logic                valid_o
);
  import kfe_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  kfe_entry_t      mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/kfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_back
// Expands each request into its value character and closing report and
// holds the oldest result on the output ports until it is taken.
// ----------------------------------------------------------------------------
module kfe_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             entry_valid_i,
  input  kfe_pkg::kfe_entry_t              entry_i,
  output logic                             entry_pop_o,
  output logic                             empty_o,
  input  logic                             pop_i,
  output logic [kfe_pkg::CharW-1:0]        value_char_o,
  output logic                             found_o,
  output logic [kfe_pkg::ValueLenW-1:0]    value_length_o,
  output logic                             finish_o
);
  import kfe_pkg::*;

  kfe_entry_t cur_q;
  logic       valid_q, char_done_q;
  logic       show_char, take, retire, load;

  assign show_char = cur_q.has_char && !char_done_q;
  assign take      = valid_q && pop_i;
  // A request with both parts stays for a second result.
  assign retire    = take && !(show_char && cur_q.finish);
  assign load      = entry_valid_i && (!valid_q || retire);

  assign entry_pop_o = load;
  assign empty_o     = !valid_q;

  // Result ports.
  assign value_char_o   = show_char ? cur_q.value_char : CharNul;
  assign found_o        = show_char ? 1'b0 : cur_q.found;
  assign value_length_o = show_char ? '0 : cur_q.value_length;
  assign finish_o       = !show_char;

  // Output stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      char_done_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q     <= 1'b1;
        char_done_q <= 1'b0;
      end else begin
        if (retire) begin
          valid_q <= 1'b0;
        end
        if (take && show_char) begin
          char_done_q <= 1'b1;
        end
      end
    end
  end

  // Output stage payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= entry_i;
    end
  end

endmodule

>>> rtl/keyed_field_extractor_unit.sv
`timescale 1ns / 1ps
// A result passes the request queue and the output stage register on its way out.
// One character per cycle is accepted while the request queue is not full; results
// leave one per cycle while taken; a value character ending its line gives two.
// The request queue between front and back holds kfe_pkg::QueueDepth requests.
// Reset: asynchronous, active low; clears the line state, the queue and the
// configuration to its defaults (key length 3, value cap 64). No clearing pass.
// ----------------------------------------------------------------------------
// keyed_field_extractor_unit
// Finds a configured key followed by '=' in a character stream and streams
// out the value that follows, closing each line with a found/length report.
// ----------------------------------------------------------------------------
module keyed_field_extractor_unit #(
  parameter int unsigned MAX_KEY_CHARS   = kfe_pkg::MaxKeyChars,
  parameter int unsigned MAX_VALUE_CHARS = kfe_pkg::MaxValueChars
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [kfe_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [kfe_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Character input.
  input  logic                          push,
  output logic                          full,
  input  logic [kfe_pkg::CharW-1:0]     text_char_i,
  input  logic                          end_of_text_i,
  // Results.
  output logic                          empty,
  input  logic                          pop,
  output logic [kfe_pkg::CharW-1:0]     value_char_o,
  output logic                          found_o,
  output logic [kfe_pkg::ValueLenW-1:0] value_length_o,
  output logic                          finish_o
);
  import kfe_pkg::*;

  logic       accept;
  logic       fe_valid;
  kfe_entry_t fe_entry;
  kfe_entry_t q_entry;
  logic       q_valid, q_pop;

  assign accept = push && !full;

  // Front: configuration, line state and classification.
  kfe_front #(
    .MAX_KEY_CHARS  (MAX_KEY_CHARS),
    .MAX_VALUE_CHARS(MAX_VALUE_CHARS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .text_char_i   (text_char_i),
    .end_of_text_i (end_of_text_i),
    .entry_valid_o (fe_valid),
    .entry_o       (fe_entry)
  );

  // Request queue between front and back.
  kfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .entry_i (fe_entry),
    .pop_i   (q_pop),
    .entry_o (q_entry),
    .full_o  (full),
    .valid_o (q_valid)
  );

  // Back: result expansion and output stage.
  kfe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_valid_i  (q_valid),
    .entry_i        (q_entry),
    .entry_pop_o    (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .value_char_o   (value_char_o),
    .found_o        (found_o),
    .value_length_o (value_length_o),
    .finish_o       (finish_o)
  );

endmodule

>>> tb/sv/kfe_extract_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_extract_checker
// Watches the character, result and configuration ports of the keyed field
// extractor, predicts every result from its own copy of the line state and
// compares the results that leave the block field by field, in order.
// ----------------------------------------------------------------------------
module kfe_extract_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kfe_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [kfe_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          push_i,
  input  logic                          full_i,
  input  logic [kfe_pkg::CharW-1:0]     text_char_i,
  input  logic                          end_of_text_i,
  input  logic                          empty_i,
  input  logic                          pop_i,
  input  logic [kfe_pkg::CharW-1:0]     value_char_i,
  input  logic                          found_i,
  input  logic [kfe_pkg::ValueLenW-1:0] value_length_i,
  input  logic                          finish_i,
  output int unsigned                   outstanding_o,
  output int unsigned                   fail_count_o,
  output int unsigned                   chars_o,
  output int unsigned                   lines_o,
  output int unsigned                   value_chars_o,
  output int unsigned                   found_lines_o
);
  import kfe_pkg::*;

  localparam int unsigned WinDepth = MaxKeyChars + 1;

  typedef struct packed {
    logic [CharW-1:0]     value_char;
    logic                 found;
    logic [ValueLenW-1:0] value_length;
    logic                 finish;
  } kfe_result_t;

  // Configuration copy.
  logic [KeyLowW-1:0]   key_low;
  logic [KeyHighW-1:0]  key_high;
  logic [KeyLenW-1:0]   key_len;
  logic [ValueCapW-1:0] value_cap;
  logic                 need_value;

  // Line state.
  logic [CharW-1:0] char_win [WinDepth];
  int unsigned      win_fill;
  int unsigned      skip_count;
  phase_e           line_phase;
  int unsigned      value_count;

  kfe_result_t extracted_q [$];
  kfe_result_t got;
  kfe_result_t want;
  int unsigned fails;
  int unsigned chars_seen;
  int unsigned lines_seen;
  int unsigned value_chars_seen;
  int unsigned found_seen;

  function automatic logic [CharW-1:0] key_char(input int unsigned idx);
    if (idx < 8) begin
      return key_low[8*idx +: 8];
    end
    if (idx < 12) begin
      return key_high[8*(idx-8) +: 8];
    end
    return CharNul;
  endfunction

  function automatic void clear_line();
    int unsigned i;
    for (i = 0; i < WinDepth; i++) begin
      char_win[i] = CharNul;
    end
    win_fill    = 0;
    skip_count  = 0;
    line_phase  = PH_SEARCH;
    value_count = 0;
  endfunction

  // Closing report of a line; the line state starts over afterwards.
  function automatic void close_line();
    kfe_result_t r;
    r.value_char   = CharNul;
    r.found        = (line_phase != PH_SEARCH) && (!need_value || value_count > 0);
    r.value_length = ValueLenW'(value_count);
    r.finish       = 1'b1;
    extracted_q.push_back(r);
    lines_seen++;
    if (r.found) begin
      found_seen++;
    end
    clear_line();
  endfunction

  // One accepted character: search for the key, copy value characters, and
  // close the line on a zero character or on the end-of-text mark.
  function automatic void extract_step(input logic [CharW-1:0] c, input logic eol);
    int unsigned klen;
    int unsigned cap;
    int unsigned i;
    logic        hit;
    logic        boundary;
    kfe_result_t r;
    chars_seen++;
    if (c == CharNul) begin
      close_line();
      return;
    end
    klen = (key_len == 0) ? 1 : ((key_len > MaxKeyChars) ? MaxKeyChars : key_len);
    if (need_value) begin
      cap = MaxValueChars;
    end else begin
      cap = (value_cap > MaxValueChars) ? MaxValueChars : value_cap;
    end

    case (line_phase)
      PH_SEARCH: begin
        // The window holds the newest character at index zero.
        hit = (win_fill >= klen);
        for (i = 0; i < klen; i++) begin
          if (hit && char_win[klen-1-i] != key_char(i)) begin
            hit = 1'b0;
          end
        end
        if (skip_count > 0) begin
          skip_count--;
        end else if (hit) begin
          boundary = (win_fill == klen) || (char_win[klen] == CharTab) ||
                     (char_win[klen] == CharSpace);
          if (boundary && c == CharEqual) begin
            line_phase = PH_VALUE;
          end else begin
            skip_count = klen - 1;
          end
        end
      end
      PH_VALUE: begin
        if (c == CharTab || c == CharCr || c == CharLf || value_count + 1 >= cap) begin
          line_phase = PH_DONE;
        end else begin
          r.value_char   = c;
          r.found        = 1'b0;
          r.value_length = '0;
          r.finish       = 1'b0;
          extracted_q.push_back(r);
          value_count++;
          value_chars_seen++;
        end
      end
      default: ;
    endcase

    for (i = WinDepth - 1; i > 0; i--) begin
      char_win[i] = char_win[i-1];
    end
    char_win[0] = c;
    if (win_fill < WinDepth) begin
      win_fill++;
    end
    if (eol) begin
      close_line();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low          = '0;
      key_high         = '0;
      key_len          = KeyLenReset;
      value_cap        = ValueCapReset;
      need_value       = 1'b0;
      fails            = 0;
      chars_seen       = 0;
      lines_seen       = 0;
      value_chars_seen = 0;
      found_seen       = 0;
      extracted_q.delete();
      clear_line();
    end else begin
      // Result request: compare with the oldest prediction.
      if (pop_i && !empty_i) begin
        got = '{value_char_i, found_i, value_length_i, finish_i};
        if (extracted_q.size() == 0) begin
          $error("unexpected result: value_char=%0h found=%0b value_length=%0d finish=%0b",
                 value_char_i, found_i, value_length_i, finish_i);
          fails++;
        end else begin
          want = extracted_q.pop_front();
          if (got.value_char !== want.value_char) begin
            $error("value_char: expected %0h, actual %0h", want.value_char, got.value_char);
            fails++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, got.found);
            fails++;
          end
          if (got.value_length !== want.value_length) begin
            $error("value_length: expected %0d, actual %0d",
                   want.value_length, got.value_length);
            fails++;
          end
          if (got.finish !== want.finish) begin
            $error("finish: expected %0b, actual %0b", want.finish, got.finish);
            fails++;
          end
        end
      end

      // Register writes.
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_KEY_LOW:      key_low    = cfg_wdata_i[KeyLowW-1:0];
          CFG_KEY_HIGH:     key_high   = cfg_wdata_i[KeyHighW-1:0];
          CFG_KEY_LEN:      key_len    = cfg_wdata_i[KeyLenW-1:0];
          CFG_VALUE_CAP:    value_cap  = cfg_wdata_i[ValueCapW-1:0];
          CFG_REQ_NONEMPTY: need_value = cfg_wdata_i[0];
          default: ;
        endcase
      end

      // Character request.
      if (push_i && !full_i) begin
        extract_step(text_char_i, end_of_text_i);
      end
    end
    outstanding_o <= extracted_q.size();
    fail_count_o  <= fails;
    chars_o       <= chars_seen;
    lines_o       <= lines_seen;
    value_chars_o <= value_chars_seen;
    found_lines_o <= found_seen;
  end

endmodule

>>> tb/sv/tb_keyed_field_extractor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_field_extractor_unit
// Feeds text lines into the keyed field extractor under several key, cap and
// span settings, with uneven stalls on both sides and one long output
// hold-off; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_keyed_field_extractor_unit;
  import kfe_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainCycles = 10;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr    = '0;
  logic [CfgDataW-1:0]  cfg_wdata   = '0;
  logic                 push        = 1'b0;
  logic                 full;
  logic [CharW-1:0]     text_char   = '0;
  logic                 end_of_text = 1'b0;
  logic                 empty;
  logic                 pop         = 1'b0;
  logic [CharW-1:0]     value_char;
  logic                 found;
  logic [ValueLenW-1:0] value_length;
  logic                 finish;

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned chars_total;
  int unsigned lines_total;
  int unsigned value_chars_total;
  int unsigned found_total;

  int unsigned      cycle_count   = 0;
  int unsigned      send_idle_pct = 24;
  int unsigned      recv_idle_pct = 73;
  logic             hold_req      = 1'b0;
  int unsigned      items_sent    = 0;
  int unsigned      key_eff       = 1;
  logic [CharW-1:0] key_bytes [MaxKeyChars];
  logic [CharW-1:0] line_q [$];

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  keyed_field_extractor_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .push          (push),
    .full          (full),
    .text_char_i   (text_char),
    .end_of_text_i (end_of_text),
    .empty         (empty),
    .pop           (pop),
    .value_char_o  (value_char),
    .found_o       (found),
    .value_length_o(value_length),
    .finish_o      (finish)
  );

  kfe_extract_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .push_i        (push),
    .full_i        (full),
    .text_char_i   (text_char),
    .end_of_text_i (end_of_text),
    .empty_i       (empty),
    .pop_i         (pop),
    .value_char_i  (value_char),
    .found_i       (found),
    .value_length_i(value_length),
    .finish_i      (finish),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count),
    .chars_o       (chars_total),
    .lines_o       (lines_total),
    .value_chars_o (value_chars_total),
    .found_lines_o (found_total)
  );

  // Result side: random stalls, or one long hold-off when asked for.
  always begin
    @(posedge clk_i);
    if (hold_req) begin
      hold_req = 1'b0;
      pop <= 1'b0;
      repeat (HoldCycles - 1) @(posedge clk_i);
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // The run stops here if results never drain.
  initial begin
    wait (cycle_count == CycleLimit);
    $display("Mismatches found");
    $finish;
  end

  // One character request; push stays high so back-to-back requests need no gap.
  task automatic send_char(input logic [CharW-1:0] c, input logic eol);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    text_char   <= c;
    end_of_text <= eol;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_line();
    int unsigned i;
    for (i = 0; i < line_q.size(); i++) begin
      send_char(line_q[i], i == line_q.size() - 1);
    end
  endtask

  task automatic send_text(input string s, input logic close);
    int unsigned i;
    line_q.delete();
    for (i = 0; i < s.len(); i++) begin
      line_q.push_back(s[i]);
    end
    if (close) begin
      send_line();
    end else begin
      for (i = 0; i < line_q.size(); i++) begin
        send_char(line_q[i], 1'b0);
      end
    end
  endtask

  // Stop offering characters and let every predicted result come out.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [KeyLowW-1:0] low, input logic [KeyHighW-1:0] high,
                            input logic [KeyLenW-1:0] len, input logic [ValueCapW-1:0] cap,
                            input logic nonempty);
    int unsigned i;
    // Upper bits of the key-high write carry junk the register must drop.
    write_reg(CFG_KEY_LOW, low);
    write_reg(CFG_KEY_HIGH, {32'($urandom), high});
    write_reg(CFG_KEY_LEN, CfgDataW'(len));
    write_reg(CFG_VALUE_CAP, CfgDataW'(cap));
    write_reg(CFG_REQ_NONEMPTY, CfgDataW'(nonempty));
    cfg_we <= 1'b0;
    key_eff = (len == 0) ? 1 : ((len > MaxKeyChars) ? MaxKeyChars : len);
    for (i = 0; i < MaxKeyChars; i++) begin
      if (i < 8) begin
        key_bytes[i] = low[8*i +: 8];
      end else begin
        key_bytes[i] = high[8*(i-8) +: 8];
      end
    end
  endtask

  // Mostly well-formed "words key=value" lines, some broken on purpose,
  // the rest noise built from key characters, separators and random bytes.
  task automatic send_random_line();
    int unsigned      pick;
    int unsigned      shape;
    int unsigned      n;
    int unsigned      m;
    int unsigned      i;
    int unsigned      j;
    logic [CharW-1:0] c;
    line_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      n = $urandom_range(0, 2);
      for (i = 0; i < n; i++) begin
        m = $urandom_range(1, 5);
        for (j = 0; j < m; j++) begin
          line_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end
        line_q.push_back($urandom_range(0, 1) ? CharSpace : CharTab);
      end
      shape = $urandom_range(0, 9);
      // Glued prefix, doubled key, or a partial key just ahead of the key.
      if (shape == 0) begin
        line_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end else if (shape == 1) begin
        for (j = 0; j < key_eff; j++) line_q.push_back(key_bytes[j]);
      end else if (shape == 2) begin
        for (j = 0; j + 1 < key_eff; j++) line_q.push_back(key_bytes[j]);
      end
      for (j = 0; j < key_eff; j++) begin
        line_q.push_back(key_bytes[j]);
      end
      // Shape three ends the line right after the key.
      if (shape != 3) begin
        line_q.push_back((shape == 4) ? 8'h3A : CharEqual);
        m = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 10);
        for (j = 0; j < m; j++) begin
          pick = $urandom_range(0, 9);
          if (pick < 8) begin
            c = 8'($urandom_range(8'h20, 8'h7E));
          end else if (pick == 8) begin
            c = 8'($urandom_range(8'h80, 8'hFF));
          end else begin
            c = 8'($urandom_range(1, 255));
          end
          line_q.push_back(c);
        end
        case ($urandom_range(0, 3))
          1: line_q.push_back(CharTab);
          2: line_q.push_back(CharCr);
          3: line_q.push_back(CharLf);
          default: ;
        endcase
        m = $urandom_range(0, 4);
        for (j = 0; j < m; j++) begin
          line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
      end
      if ($urandom_range(0, 29) == 0) begin
        line_q[$urandom_range(0, line_q.size() - 1)] = CharNul;
      end
    end else begin
      m = $urandom_range(1, 20);
      for (j = 0; j < m; j++) begin
        case ($urandom_range(0, 5))
          0: c = key_bytes[$urandom_range(0, key_eff - 1)];
          1: c = CharEqual;
          2: c = CharSpace;
          3: c = CharTab;
          default: c = 8'($urandom_range(0, 255));
        endcase
        line_q.push_back(c);
      end
    end
    send_line();
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < count) begin
      send_random_line();
    end
  endtask

  initial begin
    logic [KeyLowW-1:0]  rnd_low;
    logic [KeyHighW-1:0] rnd_high;
    int unsigned         i;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender stalls lightly, receiver heavily.
    send_idle_pct = 24;
    recv_idle_pct = 73;
    set_config(64'h0000_0000_0000_6469, 32'h0, 4'd2, 13'd8, 1'b0);

    // Directed lines with the key "id".
    send_text("id=ab\tz", 1'b1);  // value cut by a tab, tail ignored
    send_text("xid=q", 1'b1);     // key glued to a word
    send_text("id", 1'b1);        // key closes the line
    send_text(" id=", 1'b0);      // empty value after a space
    send_char(CharNul, 1'b0);     // zero character ends the line
    send_char(CharNul, 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("idid=v", 1'b1);    // overlapping occurrences are skipped
    run_random(300);

    // Longest key, smallest cap: found but nothing copied.
    wait_idle();
    set_config(64'h6867_6665_6463_6261, 32'h6C6B_6A69, 4'd12, 13'd1, 1'b0);
    run_random(200);

    // Receiver stalls lightly, sender heavily.
    send_idle_pct = 73;
    recv_idle_pct = 24;

    // Key length zero acts as one; span mode ignores a zero cap.
    wait_idle();
    set_config(64'hFFFF_FF00_1234_566B, 32'hFFFF_FFFF, 4'd0, 13'd0, 1'b0);
    run_random(120);
    wait_idle();
    set_config(64'hFFFF_FF00_1234_566B, 32'hFFFF_FFFF, 4'd0, 13'd0, 1'b1);
    run_random(120);

    // Random high-byte key with the length saturated, cap above the maximum.
    wait_idle();
    for (i = 0; i < 8; i++) begin
      rnd_low[8*i +: 8] = 8'($urandom_range(8'h21, 8'hFF));
    end
    for (i = 0; i < 4; i++) begin
      rnd_high[8*i +: 8] = 8'($urandom_range(8'h21, 8'hFF));
    end
    set_config(rnd_low, rnd_high, 4'd15, 13'd8191, 1'b0);
    run_random(250);

    // No stalls; the receiver holds off for a while to fill the block.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_idle();
    set_config(64'h0000_0000_006E_6970, 32'h0, 4'd3, 13'd4096, 1'b1);
    hold_req = 1'b1;
    run_random(250);

    // One value far longer than the random lines produce.
    line_q.delete();
    line_q.push_back(8'h70);
    line_q.push_back(8'h69);
    line_q.push_back(8'h6E);
    line_q.push_back(CharEqual);
    repeat (100) line_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
    send_line();

    wait_idle();
    set_config(64'h0000_0000_0000_6469, 32'h0, 4'd2, 13'd2, 1'b0);
    run_random(150);

    wait_idle();
    $display("Covered %0d characters in %0d closed lines: %0d value characters, %0d keys found.",
             chars_total, lines_total, value_chars_total, found_total);
    $display("Seven register settings ran under mixed stalls and one long result hold-off.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
